### sv/rsa_encrypt_decrypt_core_macros.svh
// Assertion macros shared by the RSA core modules.
// Each expects clk and rst_n to be visible at the point of use.
`ifndef RSA_ENCRYPT_DECRYPT_CORE_MACROS_SVH
`define RSA_ENCRYPT_DECRYPT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RSA core.
// No dependencies; used by rsa_mm, rsa_encrypt_decrypt_core and tb_top.
package rsa_pkg;

  localparam int W      = 16;             // operand and modulus width
  localparam int PROD_W = 2 * W;          // full product width
  localparam int CNT_W  = $clog2(PROD_W); // bit index into product
  localparam int EXP_W  = 16;             // exponent register width
  localparam int BIT_W  = $clog2(EXP_W);  // exponent bit index
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd2;

  typedef struct packed {
    logic         start;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] n;
  } mm_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] res;
  } mm_rsp_t;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_MUL,
    MM_RED
  } mm_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SETUP,
    T_SQ,
    T_SQ_W,
    T_MUL,
    T_MUL_W
  } top_state_t;

endpackage

### sv/rsa_encrypt_decrypt_core.sv
`timescale 1ns / 1ps
// Textbook RSA round trip: ciphertext = m^e mod n, recovered = c^d mod n.
// Top level; depends on rsa_pkg, rsa_mm and the assertion macros header.
//
// Usage:
//   Config: write public exponent (index 0), private exponent (index 1) and
//   modulus (index 2) on cfg_* with cfg_valid; cfg_ready is always high.
//   Write only while busy is low. Other indexes are dropped.
//   Input: a word on in_message is taken when start is high and busy low.
//   Output: out_valid pulses for one cycle with out_ciphertext and
//   out_recovered; the receiver must take the word in that cycle.
// Operation: each power is square-and-multiply over all 16 exponent bits,
//   one square plus one multiply per set bit. Every modular multiply uses
//   the shared rsa_mm unit: a registered multiply, a remainder over all 32
//   product bits (skipped when the modulus is 0), then handoff. Zero
//   exponents skip their power. One message is in flight at a time.
// Reset: synchronous, active low; exponents return to 1, modulus to 65535,
//   the sequencer to idle.
`include "rsa_encrypt_decrypt_core_macros.svh"

module rsa_encrypt_decrypt_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rsa_pkg::W-1:0]         in_message,
  output logic                          out_valid,
  output logic [rsa_pkg::W-1:0]         out_ciphertext,
  output logic [rsa_pkg::W-1:0]         out_recovered,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsa_pkg::EXP_W-1:0]     cfg_data
);

  rsa_pkg::top_state_t state_r, state_nxt;

  logic [rsa_pkg::EXP_W-1:0] pub_exp_r;
  logic [rsa_pkg::EXP_W-1:0] priv_exp_r;
  logic [rsa_pkg::W-1:0]     modulus_r;

  logic [rsa_pkg::W-1:0]     msg_r, msg_nxt;
  logic [rsa_pkg::W-1:0]     acc_r, acc_nxt;
  logic [rsa_pkg::W-1:0]     ct_r, ct_nxt;
  logic [rsa_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic                      phase_r, phase_nxt; // 0: encrypt, 1: decrypt
  logic                      out_valid_r, out_valid_nxt;
  logic [rsa_pkg::W-1:0]     out_ct_r, out_ct_nxt;
  logic [rsa_pkg::W-1:0]     out_rec_r, out_rec_nxt;

  rsa_pkg::mm_req_t mm_req;
  rsa_pkg::mm_rsp_t mm_rsp;

  logic [rsa_pkg::EXP_W-1:0] exp_cur;
  logic [rsa_pkg::W-1:0]     base_cur;
  logic                      mm_wait_st;

  assign cfg_ready = 1'b1;
  assign exp_cur   = phase_r ? priv_exp_r : pub_exp_r;
  assign base_cur  = phase_r ? ct_r : msg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_exp_r  <= rsa_pkg::EXP_W'(1);
      priv_exp_r <= rsa_pkg::EXP_W'(1);
      modulus_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsa_pkg::CFG_PUB_EXP:  pub_exp_r  <= cfg_data;
        rsa_pkg::CFG_PRIV_EXP: priv_exp_r <= cfg_data;
        rsa_pkg::CFG_MODULUS:  modulus_r  <= cfg_data[rsa_pkg::W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsa_pkg::T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    msg_r     <= msg_nxt;
    acc_r     <= acc_nxt;
    ct_r      <= ct_nxt;
    bit_r     <= bit_nxt;
    phase_r   <= phase_nxt;
    out_ct_r  <= out_ct_nxt;
    out_rec_r <= out_rec_nxt;
  end

  always_comb begin
    logic                  fin;
    logic [rsa_pkg::W-1:0] fin_val;
    logic                  adv;
    state_nxt     = state_r;
    msg_nxt       = msg_r;
    acc_nxt       = acc_r;
    ct_nxt        = ct_r;
    bit_nxt       = bit_r;
    phase_nxt     = phase_r;
    out_valid_nxt = 1'b0;
    out_ct_nxt    = out_ct_r;
    out_rec_nxt   = out_rec_r;
    mm_req.start  = 1'b0;
    mm_req.a      = acc_r;
    mm_req.b      = acc_r;
    mm_req.n      = modulus_r;
    fin           = 1'b0;
    fin_val       = acc_r;
    adv           = 1'b0;
    case (state_r)
      rsa_pkg::T_IDLE: begin
        if (start) begin
          msg_nxt   = in_message;
          phase_nxt = 1'b0;
          state_nxt = rsa_pkg::T_SETUP;
        end
      end
      rsa_pkg::T_SETUP: begin
        acc_nxt = rsa_pkg::W'(1);
        bit_nxt = '1;
        if (exp_cur == '0) begin
          // zero exponent: power is 1, unreduced
          fin     = 1'b1;
          fin_val = rsa_pkg::W'(1);
        end else begin
          state_nxt = rsa_pkg::T_SQ;
        end
      end
      rsa_pkg::T_SQ: begin
        mm_req.start = 1'b1;
        state_nxt    = rsa_pkg::T_SQ_W;
      end
      rsa_pkg::T_SQ_W: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          if (exp_cur[bit_r]) begin
            state_nxt = rsa_pkg::T_MUL;
          end else begin
            adv = 1'b1;
          end
        end
      end
      rsa_pkg::T_MUL: begin
        mm_req.start = 1'b1;
        mm_req.b     = base_cur;
        state_nxt    = rsa_pkg::T_MUL_W;
      end
      rsa_pkg::T_MUL_W: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          adv     = 1'b1;
        end
      end
      default: begin
        state_nxt = rsa_pkg::T_IDLE;
      end
    endcase

    if (adv) begin
      if (bit_r == '0) begin
        fin     = 1'b1;
        fin_val = mm_rsp.res;
      end else begin
        bit_nxt   = bit_r - 1'b1;
        state_nxt = rsa_pkg::T_SQ;
      end
    end

    if (fin) begin
      if (!phase_r) begin
        ct_nxt    = fin_val;
        phase_nxt = 1'b1;
        state_nxt = rsa_pkg::T_SETUP;
      end else begin
        out_valid_nxt = 1'b1;
        out_ct_nxt    = ct_r;
        out_rec_nxt   = fin_val;
        state_nxt     = rsa_pkg::T_IDLE;
      end
    end
  end

  rsa_mm u_mm (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mm_req),
    .rsp  (mm_rsp)
  );

  assign busy           = (state_r != rsa_pkg::T_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_ct_r;
  assign out_recovered  = out_rec_r;
  assign mm_wait_st     = (state_r == rsa_pkg::T_SQ_W) || (state_r == rsa_pkg::T_MUL_W);

  `RSA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `RSA_ASSERT_NOW(a_out_idle, out_valid, !busy, "result strobe while busy")
  `RSA_ASSERT_NEXT(a_out_pulse, out_valid, !out_valid, "result strobe longer than one cycle")
  `RSA_ASSERT_NOW(a_mm_wait, mm_rsp.done, mm_wait_st, "mm done outside wait state")

endmodule

### sv/rsa_mm.sv
`timescale 1ns / 1ps
// Iterative modular multiplier: one registered multiply, then a restoring
// remainder one product bit per cycle, skipped for a zero modulus. Depends on rsa_pkg and the macros header.
`include "rsa_encrypt_decrypt_core_macros.svh"

module rsa_mm (
  input  logic             clk,
  input  logic             rst_n,
  input  rsa_pkg::mm_req_t req,
  output rsa_pkg::mm_rsp_t rsp
);

  rsa_pkg::mm_state_t state_r, state_nxt;

  logic [rsa_pkg::W-1:0]      a_r, a_nxt;
  logic [rsa_pkg::W-1:0]      b_r, b_nxt;
  logic [rsa_pkg::W-1:0]      n_r, n_nxt;
  logic [rsa_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [rsa_pkg::W-1:0]      rem_r, rem_nxt;
  logic [rsa_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rsa_pkg::W-1:0]      res_r, res_nxt;
  logic                       done_r, done_nxt;

  logic [rsa_pkg::W:0] trial;
  logic [rsa_pkg::W:0] diff;
  logic                ge;

  assign trial = {rem_r, prod_r[cnt_r]};
  assign diff  = trial - {1'b0, n_r};
  assign ge    = (trial >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsa_pkg::MM_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    n_r    <= n_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (state_r)
      rsa_pkg::MM_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          b_nxt     = req.b;
          n_nxt     = req.n;
          state_nxt = rsa_pkg::MM_MUL;
        end
      end
      rsa_pkg::MM_MUL: begin
        prod_nxt = {{rsa_pkg::W{1'b0}}, a_r} * {{rsa_pkg::W{1'b0}}, b_r};
        rem_nxt  = '0;
        cnt_nxt  = rsa_pkg::CNT_W'(rsa_pkg::PROD_W - 1);
        if (n_r == '0) begin
          // zero modulus means 2^W: keep the low half
          res_nxt   = prod_nxt[rsa_pkg::W-1:0];
          done_nxt  = 1'b1;
          state_nxt = rsa_pkg::MM_IDLE;
        end else begin
          state_nxt = rsa_pkg::MM_RED;
        end
      end
      rsa_pkg::MM_RED: begin
        // rem stays below n, so the trial is below 2n
        rem_nxt = ge ? diff[rsa_pkg::W-1:0] : trial[rsa_pkg::W-1:0];
        if (cnt_r == '0) begin
          res_nxt   = rem_nxt;
          done_nxt  = 1'b1;
          state_nxt = rsa_pkg::MM_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = rsa_pkg::MM_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  `RSA_ASSERT_NOW(a_mm_start_idle, req.start, state_r == rsa_pkg::MM_IDLE, "mm start while busy")
  `RSA_ASSERT_NOW(a_mm_done_idle, done_r, state_r == rsa_pkg::MM_IDLE, "mm done while busy")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rsa_encrypt_decrypt_core: directed key/message table, then
// randomized key phases, each result word checked against typed-in values or a modexp model.
// Depends on rsa_pkg and the core RTL only.
module tb_top;

  localparam int PERIOD       = 10;
  localparam int RESET_CYCLES = 6;
  localparam int N_PHASES     = 9;
  localparam int PHASE_LEN    = 28;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2400;
  localparam int N_DIRECTED   = 22;
  localparam logic [rsa_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

  typedef logic [rsa_pkg::W-1:0]     val_t;
  typedef logic [rsa_pkg::EXP_W-1:0] expo_t;
  typedef logic [2*rsa_pkg::W-1:0]   wide_t;

  typedef struct packed {
    val_t ciphertext;
    val_t recovered;
  } rt_pair_t;

  typedef struct packed {
    expo_t e;
    expo_t d;
    val_t  n;
    bit    spare;   // also poke the unused register index
    val_t  msg;
    bit    known;   // c/r below are typed in
    val_t  c;
    val_t  r;
  } vec_t;

  vec_t dir_vecs [0:N_DIRECTED-1] = '{
    // reset keys: e = d = 1, n = 65535
    '{16'd1, 16'd1, 16'd65535, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{16'd1, 16'd1, 16'd65535, 1'b0, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
    '{16'd1, 16'd1, 16'd65535, 1'b0, 16'hAAAA, 1'b1, 16'hAAAA, 16'hAAAA},
    '{16'd1, 16'd1, 16'd65535, 1'b0, 16'h5555, 1'b1, 16'h5555, 16'h5555},
    '{16'd1, 16'd1, 16'd65535, 1'b1, 16'd100,  1'b1, 16'd100,  16'd100},
    // zero exponents give 1 unreduced, even for n = 1
    '{16'd0, 16'd0, 16'd65535, 1'b0, 16'd777,  1'b1, 16'd1,    16'd1},
    '{16'd0, 16'd0, 16'd1,     1'b0, 16'd5,    1'b1, 16'd1,    16'd1},
    '{16'd1, 16'd1, 16'd1,     1'b0, 16'd5,    1'b1, 16'd0,    16'd0},
    '{16'd0, 16'd1, 16'd1,     1'b0, 16'hFFFF, 1'b1, 16'd1,    16'd0},
    // textbook key p=61 q=53
    '{16'd17, 16'd2753, 16'd3233, 1'b0, 16'd65,    1'b1, 16'd2790, 16'd65},
    '{16'd17, 16'd2753, 16'd3233, 1'b0, 16'd0,     1'b1, 16'd0,    16'd0},
    '{16'd17, 16'd2753, 16'd3233, 1'b0, 16'd3232,  1'b0, 16'd0,    16'd0},
    '{16'd17, 16'd2753, 16'd3233, 1'b0, 16'hFFFF,  1'b0, 16'd0,    16'd0},
    '{16'hFFFF, 16'hFFFF, 16'd65535, 1'b0, 16'd2,     1'b0, 16'd0, 16'd0},
    '{16'hFFFF, 16'hFFFF, 16'd65535, 1'b0, 16'd65534, 1'b0, 16'd0, 16'd0},
    '{16'd3, 16'd0, 16'd3233, 1'b0, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    // n = 0 acts as 2^16
    '{16'd2, 16'd1, 16'd0, 1'b0, 16'h0101, 1'b0, 16'd0, 16'd0},
    '{16'hFFFF, 16'd1, 16'd0, 1'b0, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    '{16'hFFFF, 16'd1, 16'd2, 1'b0, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    '{16'd1, 16'hFFFF, 16'd2, 1'b0, 16'd2, 1'b0, 16'd0, 16'd0},
    '{16'h8001, 16'h7FFE, 16'd65521, 1'b0, 16'd12345, 1'b0, 16'd0, 16'd0},
    '{16'd1, 16'd1, 16'd65535, 1'b0, 16'd42, 1'b1, 16'd42, 16'd42}
  };

  // small real key sets (n, e, d)
  int key_tab_n [0:3] = '{3233, 55, 143, 64507};
  int key_tab_e [0:3] = '{17, 3, 7, 3};
  int key_tab_d [0:3] = '{2753, 27, 103, 42667};
  int edge_exp  [0:2] = '{0, 1, 65535};
  int edge_mod  [0:4] = '{0, 1, 2, 65534, 65535};

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  val_t  in_message = '0;
  logic  out_valid;
  val_t  out_ciphertext;
  val_t  out_recovered;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  expo_t cfg_data = '0;

  // key registers as the core should hold them
  expo_t key_e = 16'd1;
  expo_t key_d = 16'd1;
  val_t  key_n = 16'd65535;

  // driver-side view, used to skip redundant writes
  expo_t drv_e = 16'd1;
  expo_t drv_d = 16'd1;
  val_t  drv_n = 16'd65535;

  rt_pair_t roundtrips_due[$];
  bit       typed_ok = 1'b0;
  rt_pair_t typed_pair = '0;
  bit       quiet = 1'b0;
  int       stall_cycles = 0;
  int       n_bad = 0;
  int       n_msgs = 0;
  int       n_words = 0;
  int       n_keys = 0;

  rsa_encrypt_decrypt_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_message     (in_message),
    .out_valid      (out_valid),
    .out_ciphertext (out_ciphertext),
    .out_recovered  (out_recovered),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // n == 0 stands for 2^W: keep the low W bits
  function automatic wide_t mod_reduce(wide_t x, val_t n);
    if (n == '0) return {{rsa_pkg::W{1'b0}}, x[rsa_pkg::W-1:0]};
    return x % n;
  endfunction

  function automatic val_t modexp(val_t base, expo_t ex, val_t n);
    wide_t acc;
    if (ex == '0) return val_t'(1);
    acc = wide_t'(1);
    for (int b = rsa_pkg::EXP_W - 1; b >= 0; b--) begin
      acc = mod_reduce(acc * acc, n);
      if (ex[b]) acc = mod_reduce(acc * base, n);
    end
    return acc[rsa_pkg::W-1:0];
  endfunction

  function automatic rt_pair_t rsa_roundtrip(val_t msg, expo_t e, expo_t d, val_t n);
    rt_pair_t p;
    p.ciphertext = modexp(msg, e, n);
    p.recovered  = modexp(p.ciphertext, d, n);
    return p;
  endfunction

  // idle in about a third of the slots; some gaps long enough to span a whole word
  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 99) >= 32) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 2400);
    return $urandom_range(1, 6);
  endfunction

  always @(posedge clk) begin : monitor
    rt_pair_t want;
    if (rst_n) begin
      stall_cycles = stall_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        stall_cycles = 0;
        case (cfg_index)
          rsa_pkg::CFG_PUB_EXP:  key_e = cfg_data;
          rsa_pkg::CFG_PRIV_EXP: key_d = cfg_data;
          rsa_pkg::CFG_MODULUS:  key_n = cfg_data[rsa_pkg::W-1:0];
          default: ;  // dropped by the core
        endcase
      end
      if (start && !busy) begin
        stall_cycles = 0;
        n_msgs++;
        if (typed_ok) roundtrips_due.push_back(typed_pair);
        else roundtrips_due.push_back(rsa_roundtrip(in_message, key_e, key_d, key_n));
      end
      if (out_valid) begin
        stall_cycles = 0;
        n_words++;
        if (roundtrips_due.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected word, ciphertext %h recovered %h", $time,
                   out_ciphertext, out_recovered);
        end else begin
          want = roundtrips_due.pop_front();
          if (out_ciphertext !== want.ciphertext) begin
            n_bad++;
            $display("%0t: ciphertext mismatch, expected %h got %h", $time,
                     want.ciphertext, out_ciphertext);
          end
          if (out_recovered !== want.recovered) begin
            n_bad++;
            $display("%0t: recovered mismatch, expected %h got %h", $time,
                     want.recovered, out_recovered);
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(val_t msg, bit known, val_t c, val_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_ok   = known;
    typed_pair = '{c, r};
    in_message = msg;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [rsa_pkg::CFG_IDX_W-1:0] idx, expo_t data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // key changes only go in once the core has drained
  task automatic load_keys(expo_t e, expo_t d, val_t n, bit spare);
    if (e == drv_e && d == drv_d && n == drv_n && !spare) return;
    start = 1'b0;
    while (roundtrips_due.size() != 0 || busy) @(negedge clk);
    if (spare) cfg_write(CFG_SPARE, 16'h0007);
    if (e != drv_e) cfg_write(rsa_pkg::CFG_PUB_EXP, e);
    if (d != drv_d) cfg_write(rsa_pkg::CFG_PRIV_EXP, d);
    if (n != drv_n) cfg_write(rsa_pkg::CFG_MODULUS, n);
    cfg_valid = 1'b0;
    drv_e = e;
    drv_d = d;
    drv_n = n;
    n_keys++;
  endtask

  initial begin : stim
    expo_t e;
    expo_t d;
    val_t  n;
    val_t  msg;
    int    k;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_vecs[i]) begin
      load_keys(dir_vecs[i].e, dir_vecs[i].d, dir_vecs[i].n, dir_vecs[i].spare);
      send_word(dir_vecs[i].msg, dir_vecs[i].known, dir_vecs[i].c, dir_vecs[i].r);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      quiet = (p == 4);
      case ($urandom_range(0, 3))
        0: begin
          e = expo_t'($urandom);
          d = expo_t'($urandom);
          n = val_t'($urandom_range(1, 65535));
        end
        1: begin
          e = expo_t'(edge_exp[$urandom_range(0, 2)]);
          d = expo_t'(edge_exp[$urandom_range(0, 2)]);
          n = val_t'(edge_mod[$urandom_range(0, 4)]);
        end
        2: begin
          // messages mostly above the modulus
          e = expo_t'($urandom);
          d = expo_t'($urandom);
          n = val_t'($urandom_range(1, 16));
        end
        default: begin
          k = $urandom_range(0, 3);
          e = expo_t'(key_tab_e[k]);
          d = expo_t'(key_tab_d[k]);
          n = val_t'(key_tab_n[k]);
        end
      endcase
      load_keys(e, d, n, $urandom_range(0, 4) == 0);
      for (int j = 0; j < PHASE_LEN; j++) begin
        case ($urandom_range(0, 9))
          0: msg = '0;
          1: msg = '1;
          2, 3, 4: msg = (n != '0) ? val_t'($urandom_range(0, n - 1)) : val_t'($urandom);
          default: msg = val_t'($urandom);
        endcase
        send_word(msg, 1'b0, '0, '0);
      end
    end

    start = 1'b0;
    while (roundtrips_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d messages over %0d key loads (zero, unit and full-width",
             n_msgs, n_keys);
    $display("exponents, moduli 0/1/2/max, small real keys); %0d words checked", n_words);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
